/* src/llts_pkg.sv */
// Shared types and constants for the least-laxity task scheduler.
// No dependencies; used by llts_cell and least_laxity_task_scheduler.
package llts_pkg;

	localparam int TIME_W = 32;   // width of the tick count on the ports
	localparam int MASK_W = 8;    // width of the ready mask
	localparam int TASK_W = 3;    // width of a task index
	localparam int CFG_W  = 32;   // width of one task setting register
	localparam int REM_W  = 16;   // width of a remaining-time counter
	localparam int LAX_W  = 35;   // exact laxity before saturation

	localparam logic signed [LAX_W-1:0] LAX_HI = LAX_W'(32'h7FFF_FFFF);
	localparam logic signed [LAX_W-1:0] LAX_LO = -LAX_HI - LAX_W'(1);

	// Decision token that walks down the row of task cells.
	typedef struct packed {
		logic                     valid;
		logic [TIME_W-1:0]        now;
		logic [MASK_W-1:0]        ready;
		logic                     dec;     // the dispatched task ran this tick
		logic [TASK_W-1:0]        cur;     // the dispatched task
		logic                     have;    // a candidate has been found so far
		logic [TASK_W-1:0]        best;
		logic signed [TIME_W-1:0] lax;
	} tok_t;

endpackage

/* src/llts_cell.sv */
// One task cell: holds the task's setting, remaining time and deadline,
// updates them and folds the task into the passing decision token.
// Depends on llts_pkg.
module llts_cell #(
	parameter int TIME_BITS = 32,
	parameter int IDX       = 0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [llts_pkg::CFG_W-1:0] cfg_data,
	input  llts_pkg::tok_t            tok_in,
	output llts_pkg::tok_t            tok_out
);

	localparam int DW = TIME_BITS + 2;

	logic [llts_pkg::CFG_W-1:0] setting_q;
	logic [llts_pkg::REM_W-1:0] rem_q;
	logic [TIME_BITS-1:0]       dl_q;
	logic signed [DW-1:0]       diff_s1;
	llts_pkg::tok_t             tok_s1;
	llts_pkg::tok_t             tok_b;

	logic [TIME_BITS-1:0]       now_t;
	logic [TIME_BITS-1:0]       sum;
	logic [TIME_BITS-1:0]       dl_next;
	logic [llts_pkg::REM_W-1:0] rem_dec;
	logic                       dec_hit;
	logic                       reload;
	logic signed [DW-1:0]       diff_a;

	logic signed [llts_pkg::LAX_W-1:0]  lax_w;
	logic signed [llts_pkg::TIME_W-1:0] lax_sat;
	logic                               cand;
	logic                               take;

	// First half: decrement, reload on a reached deadline, deadline distance.
	always_comb begin
		now_t   = tok_in.now[TIME_BITS-1:0];
		sum     = now_t + TIME_BITS'(setting_q[15:0]);
		dec_hit = tok_in.dec && (tok_in.cur == llts_pkg::TASK_W'(IDX)) && (rem_q != '0);
		rem_dec = dec_hit ? rem_q - llts_pkg::REM_W'(1) : rem_q;
		reload  = tok_in.ready[IDX] && (now_t >= dl_q);
		dl_next = reload ? sum : dl_q;
		diff_a  = $signed({2'b00, dl_next}) - $signed({2'b00, now_t});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setting_q <= '0;
		end else if (cfg_we) begin
			setting_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q   <= '0;
			dl_q    <= '0;
			diff_s1 <= '0;
			tok_s1  <= '0;
		end else begin
			tok_s1 <= tok_in;
			if (tok_in.valid) begin
				dl_q    <= dl_next;
				rem_q   <= reload ? setting_q[31:16] : rem_dec;
				diff_s1 <= diff_a;
			end
		end
	end

	// Second half: laxity, saturation and the running minimum.
	always_comb begin
		lax_w = llts_pkg::LAX_W'(diff_s1)
			- llts_pkg::LAX_W'($signed({1'b0, rem_q}));
		if (lax_w > llts_pkg::LAX_HI) begin
			lax_sat = 32'sh7FFF_FFFF;
		end else if (lax_w < llts_pkg::LAX_LO) begin
			lax_sat = 32'sh8000_0000;
		end else begin
			lax_sat = lax_w[llts_pkg::TIME_W-1:0];
		end
		cand = tok_s1.ready[IDX] && (rem_q != '0);
		take = cand && (!tok_s1.have || (lax_sat < tok_s1.lax));
		tok_b = tok_s1;
		if (take) begin
			tok_b.have = 1'b1;
			tok_b.best = llts_pkg::TASK_W'(IDX);
			tok_b.lax  = lax_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_out <= '0;
		end else begin
			tok_out <= tok_b;
		end
	end

endmodule

/* src/least_laxity_task_scheduler.sv */
// Least-laxity-first scheduler: one decision per accepted tick. A tick goes through
// the input register, each task cell in turn, the held-decision register and the
// output register. A new tick is taken once the previous result has moved into the
// output register, so output stalls delay the next tick.
// Reset clears all task settings, remaining times, deadlines and dispatch state.
// Depends on llts_pkg and llts_cell.
module least_laxity_task_scheduler #(
	parameter int TASKS     = 8,
	parameter int TIME_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Tick input channel
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [llts_pkg::TIME_W-1:0]       now,
	input  logic [llts_pkg::MASK_W-1:0]       ready_mask,
	input  logic                              current_ran,
	// Decision output channel
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              found,
	output logic [llts_pkg::TASK_W-1:0]       chosen_index,
	output logic signed [llts_pkg::TIME_W-1:0] chosen_laxity,
	// Configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [llts_pkg::TASK_W-1:0]       cfg_index,
	input  logic [llts_pkg::CFG_W-1:0]        cfg_data
);

	// A tick becomes a token that enters the first task cell. Each cell first
	// applies the decrement of the running task and the reload of a reached
	// deadline to its own state, then computes its laxity and replaces the
	// carried candidate when it is strictly smaller.
	// Lower indices are visited first, so the lowest index wins a tie.
	llts_pkg::tok_t tok [TASKS+1];
	llts_pkg::tok_t tok0_q;
	llts_pkg::tok_t res_q;

	logic                        busy_q;      // a tick is in flight
	logic                        pend_q;      // a finished decision waits for the output
	logic                        out_valid_q;
	logic [llts_pkg::TASK_W-1:0] cur_q;       // last dispatched task
	logic                        disp_q;      // some task has been dispatched
	logic                        in_xfer;
	logic                        move;
	logic [TASKS:0]              tok_vld;

	assign in_ready  = !busy_q;
	assign cfg_ready = 1'b1;
	assign in_xfer   = in_valid && in_ready;
	assign move      = pend_q && (!out_valid_q || out_ready);
	assign tok[0]    = tok0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok0_q <= '0;
		end else begin
			tok0_q.valid <= in_xfer;
			if (in_xfer) begin
				tok0_q.now   <= now;
				tok0_q.ready <= ready_mask;
				tok0_q.dec   <= disp_q && current_ran;
				tok0_q.cur   <= cur_q;
				tok0_q.have  <= 1'b0;
				tok0_q.best  <= '0;
				tok0_q.lax   <= '0;
			end
		end
	end

	for (genvar g = 0; g < TASKS; g++) begin : g_cell
		llts_cell #(
			.TIME_BITS(TIME_BITS),
			.IDX      (g)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cfg_we  (cfg_valid && (cfg_index == llts_pkg::TASK_W'(g))),
			.cfg_data(cfg_data),
			.tok_in  (tok[g]),
			.tok_out (tok[g+1])
		);
	end

	for (genvar g = 0; g <= TASKS; g++) begin : g_vld
		assign tok_vld[g] = tok[g].valid;
	end

	// The token leaving the last cell carries the decision. It is held until
	// the output register is free, and only then is a new tick accepted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
			cur_q       <= '0;
			disp_q      <= 1'b0;
			res_q       <= '0;
		end else begin
			if (in_xfer) begin
				busy_q <= 1'b1;
			end
			if (tok[TASKS].valid) begin
				pend_q <= 1'b1;
				res_q  <= tok[TASKS];
				if (tok[TASKS].have) begin
					cur_q  <= tok[TASKS].best;
					disp_q <= 1'b1;
				end
			end
			if (move) begin
				pend_q      <= 1'b0;
				busy_q      <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			found         <= res_q.have;
			chosen_index  <= res_q.best;
			chosen_laxity <= res_q.lax;
		end
	end

	assign out_valid = out_valid_q;

	// Only one tick is ever in the row of cells.
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vld))
		else $error("more than one token in the cell row");

	// A decision leaves the row only while the tick is still marked in flight.
	a_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tok[TASKS].valid |-> busy_q && !pend_q)
		else $error("decision arrived with no tick in flight");

	// A new output transfer is always fed from a held decision.
	a_out_from_pend: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(pend_q))
		else $error("output appeared without a pending decision");

	// Once a task has been dispatched the scheduler never forgets it.
	a_disp_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		disp_q |=> disp_q)
		else $error("dispatch flag dropped");

	// An empty decision reports zero task and zero laxity.
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !found |-> (chosen_index == '0) && (chosen_laxity == '0))
		else $error("empty decision carries nonzero fields");

endmodule
